// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked concurrent assertions used by mrrf_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that stays active during reset.
`define ASSERT_AT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Clocked assertion that is switched off while the active-low reset is low.
`define ASSERT_AT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== rtl/core/mrrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrf_pkg
// Types, constants and the CRC-16 byte update shared by the read request framer.
// ----------------------------------------------------------------------------
package mrrf_pkg;

    localparam int BODY_LEN  = 6;
    localparam int FRAME_LEN = 8;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FC_READ_HOLDING = 8'd3;
    localparam logic [7:0] FC_READ_INPUT   = 8'd4;

    localparam logic [2:0] LAST_POS = 3'(FRAME_LEN - 1);

    typedef struct packed {
        logic [7:0]  slave_id;
        logic [7:0]  function_code;
        logic [15:0] start_address;
        logic [15:0] register_count;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [2:0] byte_position;
        logic       last_byte;
    } out_item_t;

    typedef struct packed {
        logic [BODY_LEN-1:0][7:0] body;
        logic [15:0]              crc;
    } pipe_t;

    typedef logic [FRAME_LEN-1:0][7:0] frame_t;

    function automatic logic [15:0] crc16_update_byte(input logic [15:0] crc_in,
                                                      input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/core/mrrf_crc_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrf_crc_stage
// One pipeline stage that folds one frame byte into the running CRC-16.
// ----------------------------------------------------------------------------
module mrrf_crc_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mrrf_pkg::pipe_t in_pipe,
    input  logic [7:0]      data_byte,
    output logic            out_valid,
    input  logic            out_ready,
    output mrrf_pkg::pipe_t out_pipe
);
    import mrrf_pkg::*;

    logic  valid_reg;
    pipe_t pipe_reg;
    pipe_t pipe_next;

    always_comb
    begin
        pipe_next.body = in_pipe.body;
        pipe_next.crc  = crc16_update_byte(in_pipe.crc, data_byte);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_pipe  = pipe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pipe_reg <= pipe_next;
        end
    end

endmodule

// ===== rtl/core/mrrf_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrf_serializer
// Holds one finished frame and sends its eight bytes through an output register.
// ----------------------------------------------------------------------------
module mrrf_serializer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mrrf_pkg::pipe_t     in_pipe,
    output logic                out_valid,
    input  logic                out_ready,
    output mrrf_pkg::out_item_t out_data
);
    import mrrf_pkg::*;

    logic       busy_reg;
    logic       busy_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_reg;
    out_item_t  out_next;
    frame_t     frame_reg;
    frame_t     frame_next;
    logic       out_load;
    logic       take;

    assign out_load   = !out_valid_reg || out_ready;
    assign in_ready   = !busy_reg || (out_load && (cnt_reg == LAST_POS));
    assign take       = in_valid && in_ready;
    assign frame_next = {in_pipe.crc, in_pipe.body};

    always_comb
    begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_load)
        begin
            out_valid_next = busy_reg;
        end
        if (out_load && busy_reg)
        begin
            out_next.frame_byte    = frame_reg[cnt_reg];
            out_next.byte_position = cnt_reg;
            out_next.last_byte     = (cnt_reg == LAST_POS);
            cnt_next               = cnt_reg + 3'd1;
            if (cnt_reg == LAST_POS)
            begin
                busy_next = 1'b0;
            end
        end
        if (take)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (take)
        begin
            frame_reg <= frame_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/core/modbus_read_request_framer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_read_request_framer_top
// A read request (slave id, function code 3 or 4, start register, register
// count) becomes an eight-byte Modbus RTU frame sent one byte per transaction:
// id, code, start high and low, count high and low, then the CRC-16 low byte
// and high byte, with last_byte set on the final one. Requests with any other
// function code are accepted and produce nothing. The CRC runs through six
// pipeline stages, one frame byte each, followed by the byte serializer with
// its output register. The serializer sends one byte per cycle while
// out_ready is high, eight per frame, and takes the next frame as the last
// byte of the current one goes out; the CRC stages meanwhile hold up to six
// further requests.
// ----------------------------------------------------------------------------
module modbus_read_request_framer_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mrrf_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mrrf_pkg::out_item_t out_data
);
    import mrrf_pkg::*;

    logic  stg_valid [BODY_LEN+1];
    logic  stg_ready [BODY_LEN+1];
    pipe_t stg_pipe  [BODY_LEN+1];
    logic  code_ok;

    assign code_ok = (in_data.function_code == FC_READ_HOLDING)
                  || (in_data.function_code == FC_READ_INPUT);

    assign stg_pipe[0].body = {in_data.register_count[7:0],
                               in_data.register_count[15:8],
                               in_data.start_address[7:0],
                               in_data.start_address[15:8],
                               in_data.function_code,
                               in_data.slave_id};
    assign stg_pipe[0].crc  = CRC_INIT;

    assign stg_valid[0] = in_valid && code_ok;
    assign in_ready     = stg_ready[0];

    for (genvar i = 0; i < BODY_LEN; i++)
    begin : g_crc
        mrrf_crc_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_pipe   (stg_pipe[i]),
            .data_byte (stg_pipe[i].body[i]),
            .out_valid (stg_valid[i+1]),
            .out_ready (stg_ready[i+1]),
            .out_pipe  (stg_pipe[i+1])
        );
    end

    mrrf_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[BODY_LEN]),
        .in_ready  (stg_ready[BODY_LEN]),
        .in_pipe   (stg_pipe[BODY_LEN]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/core/mrrf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrf_checker
// Port-level checks on the frame output of the read request framer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrrf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input mrrf_pkg::out_item_t out_data
);
    import mrrf_pkg::*;

    `ASSERT_AT_CLK(a_reset_idle, clk,
        !rst_n |=> !out_valid,
        "output valid during reset")

    `ASSERT_AT_CLK_RST(a_stall_hold, clk, rst_n,
        out_valid && !out_ready |=> out_valid && $stable(out_data),
        "stalled transaction changed")

    `ASSERT_AT_CLK_RST(a_last_pos, clk, rst_n,
        out_valid |-> (out_data.last_byte == (out_data.byte_position == LAST_POS)),
        "last byte flag does not match position")

    `ASSERT_AT_CLK_RST(a_next_byte, clk, rst_n,
        out_valid && out_ready && !out_data.last_byte |=> out_valid &&
            (out_data.byte_position == 3'($past(out_data.byte_position) + 3'd1)),
        "frame bytes not sent back to back")

endmodule

bind modbus_read_request_framer_top mrrf_checker u_mrrf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_checker
// Watches both channels of the read request framer. Each accepted read
// request with a read function code becomes eight predicted frame bytes with
// a locally computed CRC-16, and every output transaction is compared field
// by field with the oldest prediction.
// ----------------------------------------------------------------------------
module frame_checker
    import mrrf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        failures,
    output int        bytes_pending
);

    out_item_t frame_due[$];
    out_item_t want;
    frame_t    frame;

    initial failures = 0;

    function automatic logic [15:0] modbus_crc(input frame_t body);
        logic [15:0] acc;
        acc = CRC_INIT;
        for (int k = 0; k < BODY_LEN; k++) begin
            acc = acc ^ {8'h00, body[k]};
            for (int b = 0; b < 8; b++) begin
                acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
            end
        end
        return acc;
    endfunction

    function automatic frame_t build_frame(input in_item_t req);
        frame_t      f;
        logic [15:0] crc;
        f    = '0;
        f[0] = req.slave_id;
        f[1] = req.function_code;
        f[2] = req.start_address[15:8];
        f[3] = req.start_address[7:0];
        f[4] = req.register_count[15:8];
        f[5] = req.register_count[7:0];
        crc  = modbus_crc(f);
        f[6] = crc[7:0];
        f[7] = crc[15:8];
        return f;
    endfunction

    task automatic note_failure(input string what, input int exp_v, input int act_v);
        if (failures < 10) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, exp_v, act_v);
        end
        failures++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            frame_due.delete();
            bytes_pending <= 0;
        end
        else begin
            if (in_valid && in_ready && (in_data.function_code == FC_READ_HOLDING ||
                                         in_data.function_code == FC_READ_INPUT)) begin
                frame = build_frame(in_data);
                for (int k = 0; k < FRAME_LEN; k++) begin
                    want.frame_byte    = frame[k];
                    want.byte_position = 3'(k);
                    want.last_byte     = (3'(k) == LAST_POS);
                    frame_due.push_back(want);
                end
            end
            if (out_valid && out_ready) begin
                if (frame_due.size() == 0) begin
                    if (failures < 10) begin
                        $display("%0t: unexpected frame byte %0h at position %0d", $realtime,
                                 out_data.frame_byte, out_data.byte_position);
                    end
                    failures++;
                end
                else begin
                    want = frame_due.pop_front();
                    if (out_data.frame_byte !== want.frame_byte) begin
                        note_failure("frame_byte", want.frame_byte, out_data.frame_byte);
                    end
                    if (out_data.byte_position !== want.byte_position) begin
                        note_failure("byte_position", want.byte_position,
                                     out_data.byte_position);
                    end
                    if (out_data.last_byte !== want.last_byte) begin
                        note_failure("last_byte", want.last_byte, out_data.last_byte);
                    end
                end
            end
            bytes_pending <= frame_due.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives read requests into the framer: a directed set covering field
// extremes, both read codes and ignored codes, then random requests that are
// mostly valid reads mixed with other codes. Both channels stall in random
// bursts, except in steady stretches and in the closing part of the run.
// ----------------------------------------------------------------------------
module testbench;
    import mrrf_pkg::*;

    localparam logic [7:0] FC_ZERO           = 8'h00;
    localparam logic [7:0] FC_WRITE_SINGLE   = 8'd6;
    localparam logic [7:0] FC_WRITE_MULTIPLE = 8'd16;
    localparam logic [7:0] FC_ALL_ONES       = 8'hFF;
    localparam int         READS_WANTED      = 264;
    localparam int         CALM_FROM         = 232;
    localparam int         DRAIN_CYCLES      = 40;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    int failures;
    int bytes_pending;
    int reads_sent = 0;
    int stall_left = 0;
    bit calm = 1'b0;
    bit steady = 1'b0;

    modbus_read_request_framer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    frame_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .failures      (failures),
        .bytes_pending (bytes_pending)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk) begin
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!calm && !steady && $urandom_range(0, 5) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end
        else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_request(input logic [7:0] id, input logic [7:0] code,
                                input logic [15:0] start, input logic [15:0] count);
        if (!calm && !steady && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid               <= 1'b1;
        in_data.slave_id       <= id;
        in_data.function_code  <= code;
        in_data.start_address  <= start;
        in_data.register_count <= count;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (code == FC_READ_HOLDING || code == FC_READ_INPUT) begin
            reads_sent++;
        end
        if ($urandom_range(0, 19) == 0) begin
            steady = !steady;
        end
    endtask

    task automatic wait_for_frames;
        in_valid <= 1'b0;
        @(posedge clk);
        while (bytes_pending != 0) @(posedge clk);
    endtask

    initial begin
        logic [7:0] code;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(8'h00, FC_READ_HOLDING, 16'h0000, 16'h0000);
        send_request(8'hFF, FC_READ_INPUT, 16'hFFFF, 16'hFFFF);
        send_request(8'h01, FC_READ_HOLDING, 16'h0000, 16'h0001);
        send_request(8'h11, FC_READ_HOLDING, 16'h006B, 16'h0003);
        send_request(8'hFF, FC_READ_HOLDING, 16'h0000, 16'hFFFF);
        send_request(8'h00, FC_READ_INPUT, 16'hFFFF, 16'h0000);
        send_request(8'h01, FC_WRITE_SINGLE, 16'h0001, 16'h0003);
        send_request(8'h01, FC_WRITE_MULTIPLE, 16'h0001, 16'h0002);
        send_request(8'h22, FC_ZERO, 16'h1234, 16'h5678);
        send_request(8'h33, FC_ALL_ONES, 16'hFFFF, 16'hFFFF);
        send_request(8'h44, FC_READ_HOLDING - 8'd1, 16'h0010, 16'h0001);
        send_request(8'h55, FC_READ_INPUT + 8'd1, 16'h0010, 16'h0001);
        send_request(8'hA5, FC_READ_INPUT, 16'h5A5A, 16'hA5A5);
        send_request(8'h5A, FC_READ_HOLDING, 16'hA5A5, 16'h5A5A);
        send_request(8'h80, FC_READ_INPUT, 16'h8000, 16'h0080);
        send_request(8'h7F, FC_READ_HOLDING, 16'h7FFF, 16'h8000);
        wait_for_frames();

        while (reads_sent < READS_WANTED) begin
            if ($urandom_range(0, 4) == 0) begin
                do code = 8'($urandom_range(0, 255));
                while (code == FC_READ_HOLDING || code == FC_READ_INPUT);
            end
            else begin
                code = $urandom_range(0, 1) ? FC_READ_HOLDING : FC_READ_INPUT;
            end
            send_request(8'($urandom_range(0, 255)), code, 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)));
            if (reads_sent == READS_WANTED / 2 && bytes_pending != 0) begin
                wait_for_frames();
            end
            if (reads_sent >= CALM_FROM) begin
                calm = 1'b1;
            end
        end

        wait_for_frames();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && bytes_pending == 0) begin
            $display("CHECK OK");
        end
        else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
